[hdl/link_session_supervisor_backoff_assert.svh]
// Assertion macros used by the supervisor core module.
`ifndef LINK_SESSION_SUPERVISOR_BACKOFF_ASSERT_SVH
`define LINK_SESSION_SUPERVISOR_BACKOFF_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("supervisor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("supervisor sequencing check failed");

`endif

[hdl/lss_pkg.sv]
package lss_pkg;

	localparam int unsigned TimeW = 32;

	typedef enum logic [2:0] {
		MODE_BOOT               = 3'd0,
		MODE_LINK_CONNECTING    = 3'd1,
		MODE_LINK_UP            = 3'd2,
		MODE_SESSION_CONNECTING = 3'd3,
		MODE_CONNECTED          = 3'd4,
		MODE_LINK_LOST          = 3'd5,
		MODE_SESSION_LOST       = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		CFG_LINK_TIMEOUT     = 2'd0,
		CFG_BACKOFF_BASE     = 2'd1,
		CFG_BACKOFF_MAX      = 2'd2,
		CFG_SERVICE_INTERVAL = 2'd3
	} cfg_idx_t;

	localparam logic [TimeW-1:0] LinkTimeoutRst     = 32'd10000;
	localparam logic [TimeW-1:0] BackoffBaseRst     = 32'd2000;
	localparam logic [TimeW-1:0] BackoffMaxRst      = 32'd60000;
	localparam logic [TimeW-1:0] ServiceIntervalRst = 32'd10;

	typedef struct packed {
		logic [TimeW-1:0] link_timeout_ms;
		logic [TimeW-1:0] backoff_base_ms;
		logic [TimeW-1:0] backoff_max_ms;
		logic [TimeW-1:0] service_interval_ms;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  start_link;
		logic  drop_link;
		logic  attempt_connect;
		logic  close_session;
		logic  service_session;
		logic  announce;
		logic  connected;
	} res_t;

endpackage

[hdl/lss_cfg.sv]
module lss_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  lss_pkg::cfg_idx_t  wr_index,
	input  logic [31:0]        wr_data,
	output lss_pkg::cfg_t      cfg
);

	lss_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_timeout_ms     <= lss_pkg::LinkTimeoutRst;
			cfg_q.backoff_base_ms     <= lss_pkg::BackoffBaseRst;
			cfg_q.backoff_max_ms      <= lss_pkg::BackoffMaxRst;
			cfg_q.service_interval_ms <= lss_pkg::ServiceIntervalRst;
		end else if (wr_en) begin
			case (wr_index)
				lss_pkg::CFG_LINK_TIMEOUT:     cfg_q.link_timeout_ms     <= wr_data;
				lss_pkg::CFG_BACKOFF_BASE:     cfg_q.backoff_base_ms     <= wr_data;
				lss_pkg::CFG_BACKOFF_MAX:      cfg_q.backoff_max_ms      <= wr_data;
				lss_pkg::CFG_SERVICE_INTERVAL: cfg_q.service_interval_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/lss_core.sv]
module lss_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [31:0]   now_ms,
	input  logic          link_up,
	input  logic          session_up,
	input  lss_pkg::cfg_t cfg,
	output lss_pkg::res_t res
);

	`include "link_session_supervisor_backoff_assert.svh"

	lss_pkg::mode_t mode_q, mode_d;
	logic [31:0] link_start_q, link_start_d;
	logic [31:0] attempt_time_q, attempt_time_d;
	logic [31:0] service_time_q, service_time_d;
	logic [31:0] backoff_q, backoff_d;

	logic [31:0] link_elapsed, attempt_elapsed, service_elapsed;
	logic        link_timed_out, retry_due, service_due;
	logic [32:0] backoff_dbl;
	logic [31:0] backoff_next;

	// Elapsed times wrap modulo 2^32.
	assign link_elapsed    = now_ms - link_start_q;
	assign attempt_elapsed = now_ms - attempt_time_q;
	assign service_elapsed = now_ms - service_time_q;
	assign link_timed_out  = link_elapsed > cfg.link_timeout_ms;
	assign retry_due       = attempt_elapsed >= backoff_q;
	assign service_due     = service_elapsed >= cfg.service_interval_ms;

	// Doubling is done one bit wider, so it saturates at the cap.
	assign backoff_dbl  = {backoff_q, 1'b0};
	assign backoff_next = (backoff_dbl > {1'b0, cfg.backoff_max_ms}) ?
		cfg.backoff_max_ms : backoff_dbl[31:0];

	always_comb begin
		mode_d         = mode_q;
		link_start_d   = link_start_q;
		attempt_time_d = attempt_time_q;
		service_time_d = service_time_q;
		backoff_d      = backoff_q;
		case (mode_q)
			lss_pkg::MODE_LINK_CONNECTING: begin
				if (link_up) begin
					mode_d = lss_pkg::MODE_LINK_UP;
				end else if (link_timed_out) begin
					link_start_d = now_ms;
				end
			end
			lss_pkg::MODE_LINK_UP, lss_pkg::MODE_SESSION_LOST: begin
				backoff_d      = cfg.backoff_base_ms;
				mode_d         = lss_pkg::MODE_SESSION_CONNECTING;
				attempt_time_d = now_ms;
			end
			lss_pkg::MODE_SESSION_CONNECTING: begin
				if (session_up) begin
					backoff_d = cfg.backoff_base_ms;
					mode_d    = lss_pkg::MODE_CONNECTED;
				end else if (retry_due) begin
					backoff_d = backoff_next;
					if (!link_up) begin
						mode_d = lss_pkg::MODE_LINK_LOST;
					end else begin
						attempt_time_d = now_ms;
					end
				end
			end
			lss_pkg::MODE_CONNECTED: begin
				if (!link_up) begin
					mode_d = lss_pkg::MODE_LINK_LOST;
				end else if (!session_up) begin
					mode_d = lss_pkg::MODE_SESSION_LOST;
				end else if (service_due) begin
					service_time_d = now_ms;
				end
			end
			default: begin
				link_start_d = now_ms;
				mode_d       = lss_pkg::MODE_LINK_CONNECTING;
			end
		endcase
	end

	always_comb begin
		res                 = '0;
		res.mode            = mode_d;
		res.connected       = (mode_d == lss_pkg::MODE_CONNECTED);
		case (mode_q)
			lss_pkg::MODE_LINK_CONNECTING: begin
				res.start_link = !link_up && link_timed_out;
				res.drop_link  = !link_up && link_timed_out;
			end
			lss_pkg::MODE_LINK_UP, lss_pkg::MODE_SESSION_LOST: begin
				res.attempt_connect = 1'b1;
			end
			lss_pkg::MODE_SESSION_CONNECTING: begin
				res.announce        = session_up;
				res.attempt_connect = !session_up && retry_due && link_up;
			end
			lss_pkg::MODE_CONNECTED: begin
				res.close_session   = !link_up;
				res.service_session = link_up && session_up && service_due;
			end
			default: begin
				res.start_link = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= lss_pkg::MODE_BOOT;
			link_start_q   <= '0;
			attempt_time_q <= '0;
			service_time_q <= '0;
			backoff_q      <= lss_pkg::BackoffBaseRst;
		end else if (fire) begin
			mode_q         <= mode_d;
			link_start_q   <= link_start_d;
			attempt_time_q <= attempt_time_d;
			service_time_q <= service_time_d;
			backoff_q      <= backoff_d;
		end
	end

	`LSS_ASSERT_IMPLY(a_drop_restarts, clk, arst_n, res.drop_link, res.start_link)
	`LSS_ASSERT_IMPLY(a_session_cmds_excl, clk, arst_n, 1'b1,
		$onehot0({res.attempt_connect, res.close_session, res.service_session, res.announce}))
	`LSS_ASSERT_NEXT(a_boot_leaves, clk, arst_n, fire && (mode_q == lss_pkg::MODE_BOOT),
		mode_q == lss_pkg::MODE_LINK_CONNECTING)
	`LSS_ASSERT_NEXT(a_backoff_hold, clk, arst_n, !fire, $stable(backoff_q))

endmodule

[hdl/link_session_supervisor_backoff.sv]
// Link and session supervisor with capped exponential backoff. Each input beat is one tick
// carrying a millisecond timestamp and the link and session status; each tick yields exactly
// one output beat with the mode after the tick, the command pulses and the connected flag.
// A tick is taken into an input register, evaluated combinationally against the supervisor
// state, and its result is held in an output register, so one tick per cycle is sustained
// while the consumer keeps out_ready high. The result beat becomes valid once its tick has
// moved from the input register into the output register. The supervisor state is updated
// in the cycle the tick moves into the output register, so back-to-back ticks always see the
// state left by the previous one. Configuration writes are accepted in every cycle and take
// effect on the next evaluated tick; a new backoff base reaches the running interval only when
// the mode machine reloads it. Elapsed times are computed modulo 2^32.
module link_session_supervisor_backoff (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic        link_up,
	input  logic        session_up,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  mode,
	output logic        start_link,
	output logic        drop_link,
	output logic        attempt_connect,
	output logic        close_session,
	output logic        service_session,
	output logic        announce,
	output logic        connected,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic          valid_s1;
	logic [31:0]   now_s1;
	logic          link_s1;
	logic          sess_s1;
	logic          out_valid_q;
	lss_pkg::res_t out_q;
	lss_pkg::res_t res;
	lss_pkg::cfg_t cfg;
	logic          advance;
	logic          fire;

	// The output register can take a new result when it is empty or being drained.
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;

	lss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (lss_pkg::cfg_idx_t'(cfg_index)),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lss_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.now_ms     (now_s1),
		.link_up    (link_s1),
		.session_up (sess_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// Input register: holds one tick until the core evaluates it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1  <= now_ms;
			link_s1 <= link_up;
			sess_s1 <= session_up;
		end
	end

	// Output register: holds one result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign mode            = out_q.mode;
	assign start_link      = out_q.start_link;
	assign drop_link       = out_q.drop_link;
	assign attempt_connect = out_q.attempt_connect;
	assign close_session   = out_q.close_session;
	assign service_session = out_q.service_session;
	assign announce        = out_q.announce;
	assign connected       = out_q.connected;

endmodule
